/* hw/rtl/qau_pkg.sv */
// Package for the quaternion arithmetic unit: word format, opcodes, shared types
// and the rounding and saturation helpers.
// No dependencies; every other file imports it.
`default_nettype none

package qau_pkg;

  // Word format: signed Q2.14.
  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 14;

  // Accumulator wide enough for a sum of four products, doubled.
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int ACC_BITS  = 2 * WORD_BITS + 3;

  // Normalize path sizes: square root bits and quotient bits.
  localparam int ROOT_BITS = WORD_BITS + 1;
  localparam int QUO_BITS  = FRAC_BITS + 1;
  localparam int NORM_LAT  = ROOT_BITS + QUO_BITS + 4;

  // Front pipeline depth for the product paths.
  localparam int FRONT_LAT = 4;

  // Opcodes.
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_ROT  = 2'd1;
  localparam logic [1:0] OP_CONJ = 2'd2;
  localparam logic [1:0] OP_NORM = 2'd3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } wsat_t;

  // Result of the normalize unit.
  typedef struct packed {
    logic [3:0][WORD_BITS-1:0] r;
    logic                      sat;
    logic                      zn;
  } norm_res_t;

  localparam acc_t ACC_MAX  = acc_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam acc_t ACC_MIN  = -ACC_MAX - acc_t'(1);
  localparam acc_t ACC_HALF = acc_t'(1) << (FRAC_BITS - 1);

  // Clip a wide value to the word and flag the clip.
  function automatic wsat_t sat_word(input acc_t v);
    wsat_t res;
    if (v > ACC_MAX) begin
      res.val = {1'b0, {(WORD_BITS-1){1'b1}}};
      res.sat = 1'b1;
    end else if (v < ACC_MIN) begin
      res.val = {1'b1, {(WORD_BITS-1){1'b0}}};
      res.sat = 1'b1;
    end else begin
      res.val = v[WORD_BITS-1:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

  // Round half up from 2*FRAC_BITS to FRAC_BITS fraction bits, then saturate.
  function automatic wsat_t rnd_sat(input acc_t v);
    acc_t t;
    t = (v + ACC_HALF) >>> FRAC_BITS;
    return sat_word(t);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/qau_norm.sv */
// Normalize pipeline: squares, sum, bit-per-stage square root, then four
// bit-per-stage restoring dividers and the final sign, clip and zero check.
// Depends on qau_pkg.
`default_nettype none

module qau_norm
  import qau_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [3:0][WORD_BITS-1:0] a_i,
  output norm_res_t                      res_o
);

  localparam int SB  = 2 * WORD_BITS + 1;
  localparam int XB  = 2 * ROOT_BITS + 1;
  localparam int DB  = ROOT_BITS + QUO_BITS;
  localparam int SIDE_N = ROOT_BITS + QUO_BITS + 3;

  typedef struct packed {
    logic [3:0][WORD_BITS-1:0] mag;
    logic [3:0]                neg;
    logic                      zero;
  } side_t;

  side_t                    side_r [SIDE_N];
  logic [PROD_BITS-1:0]     sq_r   [4];
  logic [XB-1:0]            srem_r [ROOT_BITS+1];
  logic [ROOT_BITS-1:0]     sroot_r[ROOT_BITS+1];
  logic [DB-1:0]            drem_r [QUO_BITS+1][4];
  logic [QUO_BITS-1:0]      dq_r   [QUO_BITS+1][4];
  logic [ROOT_BITS-1:0]     den_r  [QUO_BITS+1];
  norm_res_t                res_r;

  // Stage one: squares, magnitudes and signs.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        sq_r[l]             <= PROD_BITS'(word_t'(a_i[l]) * word_t'(a_i[l]));
        side_r[0].mag[l]    <= a_i[l][WORD_BITS-1] ? WORD_BITS'(-a_i[l]) : a_i[l];
        side_r[0].neg[l]    <= a_i[l][WORD_BITS-1];
      end
      side_r[0].zero <= 1'b0;
    end
  end

  // Stage two: sum of squares and the zero check.
  logic [SB-1:0] sum;
  always_comb begin
    sum = SB'(sq_r[0]) + SB'(sq_r[1]) + SB'(sq_r[2]) + SB'(sq_r[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srem_r[0]      <= XB'(sum);
      sroot_r[0]     <= '0;
      side_r[1].mag  <= side_r[0].mag;
      side_r[1].neg  <= side_r[0].neg;
      side_r[1].zero <= (sum == '0);
    end
  end

  // Square root, one result bit per stage, most significant first.
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    localparam int BI = ROOT_BITS - 1 - k;
    logic [XB-1:0] trial;
    assign trial = (XB'(sroot_r[k]) << (BI + 1)) | (XB'(1) << (2 * BI));

    always_ff @(posedge clk) begin
      if (en) begin
        if (srem_r[k] >= trial) begin
          srem_r[k+1]  <= srem_r[k] - trial;
          sroot_r[k+1] <= sroot_r[k] | (ROOT_BITS'(1) << BI);
        end else begin
          srem_r[k+1]  <= srem_r[k];
          sroot_r[k+1] <= sroot_r[k];
        end
        side_r[k+2] <= side_r[k+1];
      end
    end
  end

  // Numerators with half the divisor added for round half away from zero.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        drem_r[0][l] <= DB'({side_r[ROOT_BITS+1].mag[l], {FRAC_BITS{1'b0}}})
                        + DB'(sroot_r[ROOT_BITS] >> 1);
        dq_r[0][l]   <= '0;
      end
      den_r[0]              <= sroot_r[ROOT_BITS];
      side_r[ROOT_BITS+2]   <= side_r[ROOT_BITS+1];
    end
  end

  // Restoring division, one quotient bit per stage in all four lanes.
  for (genvar jj = 0; jj < QUO_BITS; jj++) begin : g_div
    localparam int BJ = QUO_BITS - 1 - jj;
    logic [DB-1:0] dsub;
    assign dsub = DB'(den_r[jj]) << BJ;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 4; l++) begin
          if (drem_r[jj][l] >= dsub) begin
            drem_r[jj+1][l] <= drem_r[jj][l] - dsub;
            dq_r[jj+1][l]   <= dq_r[jj][l] | (QUO_BITS'(1) << BJ);
          end else begin
            drem_r[jj+1][l] <= drem_r[jj][l];
            dq_r[jj+1][l]   <= dq_r[jj][l];
          end
        end
        den_r[jj+1]             <= den_r[jj];
        side_r[ROOT_BITS+3+jj]  <= side_r[ROOT_BITS+2+jj];
      end
    end
  end

  // Final stage: apply signs, clip, and force zeros for a zero norm.
  side_t     fside;
  norm_res_t res_nxt;
  acc_t      sv;
  wsat_t     cl;
  always_comb begin
    fside   = side_r[SIDE_N-1];
    res_nxt = '0;
    sv      = '0;
    cl      = '0;
    for (int l = 0; l < 4; l++) begin
      sv = acc_t'({1'b0, dq_r[QUO_BITS][l]});
      if (fside.neg[l]) begin
        sv = -sv;
      end
      cl = sat_word(sv);
      res_nxt.r[l] = cl.val;
      res_nxt.sat  = res_nxt.sat | cl.sat;
    end
    if (fside.zero) begin
      res_nxt = '0;
      res_nxt.zn = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

`default_nettype wire

/* hw/rtl/quaternion_arith_unit_core.sv */
// Quaternion arithmetic unit: multiply, rotate vector, conjugate, normalize.
// Every opcode has the same latency from input transfer to output.
// Throughput: one item per cycle; the normalize square root and divider stages set the depth.
// The whole pipeline advances together and holds while the output waits.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
`default_nettype none

module quaternion_arith_unit_core
  import qau_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // in_tdata: a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z (from bit 0 up).
  input  wire logic [8*WORD_BITS-1:0] in_tdata,
  // in_tuser: opcode.
  input  wire logic [1:0]             in_tuser,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // out_tdata: r_w, r_x, r_y, r_z (from bit 0 up).
  output logic [4*WORD_BITS-1:0]      out_tdata,
  // out_tuser: saturated, zero_norm (from bit 0 up).
  output logic [1:0]                  out_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready
);

  localparam int DL = NORM_LAT - FRONT_LAT;

  logic adv;
  logic vld_r [NORM_LAT];
  logic out_valid_r;

  // Whole pipeline moves when the output register is free or being drained.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NORM_LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < NORM_LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[NORM_LAT-1];
    end
  end

  // Stage one: all cross products A*B and B*B.
  word_t      ia [4];
  word_t      ib [4];
  logic [1:0] op1_r;
  word_t      a1_r  [4];
  prod_t      ab1_r [4][4];
  prod_t      bb1_r [4][4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ia[i] = in_tdata[WORD_BITS*i +: WORD_BITS];
      ib[i] = in_tdata[WORD_BITS*(i+4) +: WORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= in_tuser;
      for (int i = 0; i < 4; i++) begin
        a1_r[i] <= ia[i];
        for (int j = 0; j < 4; j++) begin
          ab1_r[i][j] <= ia[i] * ib[j];
          bb1_r[i][j] <= ib[i] * ib[j];
        end
      end
    end
  end

  // Stage two: Hamilton product, conjugate and the rotation matrix of B.
  acc_t  pa [4][4];
  acc_t  pb [4][4];
  acc_t  msum [9];
  acc_t  hsum [4];
  wsat_t mq [9];
  wsat_t hq [4];
  wsat_t cq [3];
  word_t res2_nxt [4];
  logic  sat2_nxt;
  logic  msat2_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pa[i][j] = acc_t'(ab1_r[i][j]);
        pb[i][j] = acc_t'(bb1_r[i][j]);
      end
    end
    hsum[0] = pa[0][0] - pa[1][1] - pa[2][2] - pa[3][3];
    hsum[1] = pa[0][1] + pa[1][0] + pa[2][3] - pa[3][2];
    hsum[2] = pa[0][2] - pa[1][3] + pa[2][0] + pa[3][1];
    hsum[3] = pa[0][3] + pa[1][2] - pa[2][1] + pa[3][0];
    msum[0] = pb[0][0] + pb[1][1] - pb[2][2] - pb[3][3];
    msum[4] = pb[0][0] - pb[1][1] + pb[2][2] - pb[3][3];
    msum[8] = pb[0][0] - pb[1][1] - pb[2][2] + pb[3][3];
    msum[1] = (pb[1][2] - pb[0][3]) <<< 1;
    msum[3] = (pb[1][2] + pb[0][3]) <<< 1;
    msum[2] = (pb[1][3] + pb[0][2]) <<< 1;
    msum[6] = (pb[1][3] - pb[0][2]) <<< 1;
    msum[5] = (pb[2][3] - pb[0][1]) <<< 1;
    msum[7] = (pb[2][3] + pb[0][1]) <<< 1;

    msat2_nxt = 1'b0;
    for (int e = 0; e < 9; e++) begin
      mq[e]     = rnd_sat(msum[e]);
      msat2_nxt = msat2_nxt | mq[e].sat;
    end
    for (int i = 0; i < 4; i++) begin
      hq[i] = rnd_sat(hsum[i]);
    end
    for (int i = 0; i < 3; i++) begin
      cq[i] = sat_word(-acc_t'(a1_r[i+1]));
    end

    if (op1_r == OP_CONJ) begin
      res2_nxt[0] = a1_r[0];
      for (int i = 0; i < 3; i++) begin
        res2_nxt[i+1] = cq[i].val;
      end
      sat2_nxt = cq[0].sat | cq[1].sat | cq[2].sat;
    end else begin
      for (int i = 0; i < 4; i++) begin
        res2_nxt[i] = hq[i].val;
      end
      sat2_nxt = hq[0].sat | hq[1].sat | hq[2].sat | hq[3].sat;
    end
  end

  logic [1:0] op2_r;
  word_t      res2_r [4];
  logic       sat2_r;
  word_t      m2_r [9];
  logic       msat2_r;
  word_t      v2_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      op2_r   <= op1_r;
      sat2_r  <= sat2_nxt;
      msat2_r <= msat2_nxt;
      for (int i = 0; i < 4; i++) begin
        res2_r[i] <= res2_nxt[i];
      end
      for (int e = 0; e < 9; e++) begin
        m2_r[e] <= mq[e].val;
      end
      for (int i = 0; i < 3; i++) begin
        v2_r[i] <= a1_r[i+1];
      end
    end
  end

  // Stage three: matrix times vector products.
  logic [1:0] op3_r;
  word_t      res3_r [4];
  logic       sat3_r;
  logic       msat3_r;
  prod_t      mv3_r [3][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      op3_r   <= op2_r;
      sat3_r  <= sat2_r;
      msat3_r <= msat2_r;
      for (int i = 0; i < 4; i++) begin
        res3_r[i] <= res2_r[i];
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mv3_r[i][j] <= m2_r[3*i+j] * v2_r[j];
        end
      end
    end
  end

  // Stage four: rotated vector sums, and the choice of front result.
  wsat_t rq [3];
  word_t res4_nxt [4];
  logic  sat4_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rq[i] = rnd_sat(acc_t'(mv3_r[i][0]) + acc_t'(mv3_r[i][1]) + acc_t'(mv3_r[i][2]));
    end
    if (op3_r == OP_ROT) begin
      res4_nxt[0] = '0;
      for (int i = 0; i < 3; i++) begin
        res4_nxt[i+1] = rq[i].val;
      end
      sat4_nxt = msat3_r | rq[0].sat | rq[1].sat | rq[2].sat;
    end else begin
      for (int i = 0; i < 4; i++) begin
        res4_nxt[i] = res3_r[i];
      end
      sat4_nxt = sat3_r;
    end
  end

  logic [1:0] op4_r;
  word_t      res4_r [4];
  logic       sat4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      op4_r  <= op3_r;
      sat4_r <= sat4_nxt;
      for (int i = 0; i < 4; i++) begin
        res4_r[i] <= res4_nxt[i];
      end
    end
  end

  // Delay line that matches the front results to the normalize latency.
  logic [1:0] dop_r  [DL];
  word_t      dres_r [DL][4];
  logic       dsat_r [DL];

  always_ff @(posedge clk) begin
    if (adv) begin
      dop_r[0]  <= op4_r;
      dsat_r[0] <= sat4_r;
      for (int i = 0; i < 4; i++) begin
        dres_r[0][i] <= res4_r[i];
      end
      for (int k = 1; k < DL; k++) begin
        dop_r[k]  <= dop_r[k-1];
        dsat_r[k] <= dsat_r[k-1];
        for (int i = 0; i < 4; i++) begin
          dres_r[k][i] <= dres_r[k-1][i];
        end
      end
    end
  end

  // Normalize unit runs beside the front and the delay line.
  logic [3:0][WORD_BITS-1:0] norm_a;
  norm_res_t                 norm_res;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      norm_a[i] = ia[i];
    end
  end

  qau_norm u_norm (
    .clk   (clk),
    .en    (adv),
    .a_i   (norm_a),
    .res_o (norm_res)
  );

  // Output register.
  logic [4*WORD_BITS-1:0] out_data_r;
  logic [1:0]             out_user_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dop_r[DL-1] == OP_NORM) begin
        out_data_r <= norm_res.r;
        out_user_r <= {norm_res.zn, norm_res.sat};
      end else begin
        out_data_r <= {dres_r[DL-1][3], dres_r[DL-1][2], dres_r[DL-1][1], dres_r[DL-1][0]};
        out_user_r <= {1'b0, dsat_r[DL-1]};
      end
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

`ifndef ASSERT_OFF
  // A zero norm result carries zeros and no saturation.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r[1] |-> (out_data_r == '0) && !out_user_r[0])
    else $error("zero_norm result is not all zeros");

  // A rotation leaves the scalar part at zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[FRONT_LAT-1] && (op4_r == OP_ROT) |-> (res4_r[0] == '0))
    else $error("rotate result has a nonzero scalar part");

  // A held output keeps the whole pipeline frozen.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(vld_r[NORM_LAT-1]) && $stable(op4_r))
    else $error("pipeline moved while the output was stalled");
`endif

endmodule

`default_nettype wire

/* tb/sv/quaternion_arith_unit_core_tb.sv */
// Self-checking testbench for quaternion_arith_unit_core: multiply, rotate, conjugate
// and normalize items on a stream bus with random idling on both sides.
// Depends on qau_pkg for the word format and opcodes.
`timescale 1ns / 100ps

module quaternion_arith_unit_core_tb
  import qau_pkg::*;
;

  typedef struct {
    logic [1:0] op;
    word_t      a [4];
    word_t      b [4];
    bit         drain_first;
  } quat_item_t;

  typedef struct {
    word_t r [4];
    logic  sat;
    logic  zn;
  } quat_res_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 120;

  logic                   clk;
  logic                   rst_n;
  logic [8*WORD_BITS-1:0] in_tdata;
  logic [1:0]             in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [4*WORD_BITS-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tvalid;
  logic                   out_tready;

  quat_item_t pending_items [$];
  quat_res_t  expected_results [$];
  quat_item_t held_item;
  bit         held_taken;
  int         error_count;
  int         cycle_count;
  int         quiet_cycles;

  quaternion_arith_unit_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  // Clock and a single reset pulse at the start.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Round half up from 2*FRAC_BITS fraction bits, then clip to the word.
  function automatic longint round_clip(input longint v, inout logic sat);
    longint t;
    t = (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    return clip_word(t, sat);
  endfunction

  function automatic longint clip_word(input longint v, inout logic sat);
    longint hi;
    longint lo;
    hi = (longint'(1) << (WORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint floor_sqrt(input longint x);
    longint r;
    longint bitv;
    r = 0;
    bitv = longint'(1) << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Expected result of one item.
  function automatic quat_res_t quat_predict(input quat_item_t it);
    quat_res_t res;
    longint a [4];
    longint b [4];
    longint m [9];
    longint s;
    longint nrm;
    longint mag;
    longint q;
    logic   sat;
    sat = 1'b0;
    res.zn = 1'b0;
    for (int i = 0; i < 4; i++) begin
      a[i] = it.a[i];
      b[i] = it.b[i];
      res.r[i] = '0;
    end
    case (it.op)
      OP_MUL: begin
        res.r[0] = word_t'(round_clip(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3], sat));
        res.r[1] = word_t'(round_clip(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2], sat));
        res.r[2] = word_t'(round_clip(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1], sat));
        res.r[3] = word_t'(round_clip(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0], sat));
      end
      OP_ROT: begin
        m[0] = round_clip(b[0]*b[0] + b[1]*b[1] - b[2]*b[2] - b[3]*b[3], sat);
        m[4] = round_clip(b[0]*b[0] - b[1]*b[1] + b[2]*b[2] - b[3]*b[3], sat);
        m[8] = round_clip(b[0]*b[0] - b[1]*b[1] - b[2]*b[2] + b[3]*b[3], sat);
        m[1] = round_clip(2 * (b[1]*b[2] - b[0]*b[3]), sat);
        m[3] = round_clip(2 * (b[1]*b[2] + b[0]*b[3]), sat);
        m[2] = round_clip(2 * (b[1]*b[3] + b[0]*b[2]), sat);
        m[6] = round_clip(2 * (b[1]*b[3] - b[0]*b[2]), sat);
        m[5] = round_clip(2 * (b[2]*b[3] - b[0]*b[1]), sat);
        m[7] = round_clip(2 * (b[2]*b[3] + b[0]*b[1]), sat);
        for (int i = 0; i < 3; i++)
          res.r[i+1] = word_t'(round_clip(m[3*i]*a[1] + m[3*i+1]*a[2] + m[3*i+2]*a[3],
                                          sat));
      end
      OP_CONJ: begin
        res.r[0] = it.a[0];
        for (int i = 1; i < 4; i++) res.r[i] = word_t'(clip_word(-a[i], sat));
      end
      default: begin
        s = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
        if (s == 0) begin
          res.zn = 1'b1;
        end else begin
          nrm = floor_sqrt(s);
          for (int i = 0; i < 4; i++) begin
            mag = (a[i] < 0) ? -a[i] : a[i];
            q = ((mag << FRAC_BITS) + nrm / 2) / nrm;
            res.r[i] = word_t'(clip_word((a[i] < 0) ? -q : q, sat));
          end
        end
      end
    endcase
    res.sat = sat;
    return res;
  endfunction

  function automatic quat_item_t make_item(input logic [1:0] op, input int a0, a1, a2, a3,
                                           input int b0, b1, b2, b3);
    quat_item_t it;
    it.op = op;
    it.a[0] = word_t'(a0); it.a[1] = word_t'(a1);
    it.a[2] = word_t'(a2); it.a[3] = word_t'(a3);
    it.b[0] = word_t'(b0); it.b[1] = word_t'(b1);
    it.b[2] = word_t'(b2); it.b[3] = word_t'(b3);
    it.drain_first = 1'b0;
    return it;
  endfunction

  // A component either over the full range or near the unit scale.
  function automatic int rand_comp(input bit unit_scale);
    if (unit_scale) return $urandom_range(0, 32768) - 16384;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  // Stimulus: directed corners, then random items.
  initial begin
    quat_item_t it;
    bit unit_scale;
    pending_items.push_back(make_item(OP_MUL, 16384, 0, 0, 0, 16384, 0, 0, 0));
    pending_items.push_back(make_item(OP_MUL, 32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767));
    pending_items.push_back(make_item(OP_MUL, -32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768));
    pending_items.push_back(make_item(OP_MUL, -32768, 32767, -32768, 32767,
                                      32767, -32768, 32767, -32768));
    pending_items.push_back(make_item(OP_MUL, 1, -1, 1, -1, 8192, 8192, -8192, 1));
    pending_items.push_back(make_item(OP_ROT, 0, 16384, 0, 0, 11585, 0, 0, 11585));
    pending_items.push_back(make_item(OP_ROT, 32767, 32767, -32768, 32767,
                                      16384, 0, 0, 0));
    pending_items.push_back(make_item(OP_ROT, 0, 16384, 16384, 16384,
                                      32767, 32767, 32767, 32767));
    pending_items.push_back(make_item(OP_ROT, -32768, -32768, -32768, -32768,
                                      -32768, 32767, -32768, 32767));
    pending_items.push_back(make_item(OP_CONJ, -32768, -32768, -32768, -32768, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_CONJ, 32767, 32767, 32767, 32767,
                                      -1, -1, -1, -1));
    pending_items.push_back(make_item(OP_CONJ, 0, 1, -1, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_NORM, 0, 0, 0, 0, 123, -5, 7, 9));
    pending_items.push_back(make_item(OP_NORM, -32768, -32768, -32768, -32768, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_NORM, 0, 0, 0, -1, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_NORM, 32767, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_NORM, 1, 1, 1, 1, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_NORM, 32767, -32768, 1, 0, 0, 0, 0, 0));
    for (int n = 0; n < 1350; n++) begin
      unit_scale = ($urandom_range(0, 99) < 40);
      it.op = 2'($urandom_range(0, 3));
      for (int i = 0; i < 4; i++) begin
        it.a[i] = word_t'(rand_comp(unit_scale));
        it.b[i] = word_t'(rand_comp(unit_scale));
      end
      // Occasionally tiny vectors, to hit small norms in normalize.
      if ($urandom_range(0, 19) == 0)
        for (int i = 0; i < 4; i++) it.a[i] = word_t'($urandom_range(0, 4) - 2);
      it.drain_first = (n == 700);
      pending_items.push_back(it);
    end
    wait (pending_items.size() == 0 && !in_tvalid);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Driver: inputs change on the falling edge.
  initial begin
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    held_taken = 1'b0;
  end

  always @(negedge clk) begin
    bit calm;
    calm = (cycle_count > 400 && cycle_count < 900);
    out_tready <= calm || ($urandom_range(0, 99) >= 34);
    if (rst_n && (!in_tvalid || held_taken)) begin
      held_taken = 1'b0;
      if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 34) &&
          !(pending_items[0].drain_first && expected_results.size() != 0)) begin
        held_item = pending_items.pop_front();
        in_tuser <= held_item.op;
        for (int i = 0; i < 4; i++) begin
          in_tdata[i*WORD_BITS +: WORD_BITS]     <= held_item.a[i];
          in_tdata[(i+4)*WORD_BITS +: WORD_BITS] <= held_item.b[i];
        end
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: record input transfers and check output transfers on the rising edge.
  always @(posedge clk) begin
    quat_res_t want;
    bit moved;
    cycle_count++;
    moved = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      expected_results.push_back(quat_predict(held_item));
      held_taken = 1'b1;
      moved = 1'b1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      moved = 1'b1;
      if (expected_results.size() == 0) begin
        $error("unexpected output transfer: tdata=%h tuser=%b", out_tdata, out_tuser);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        for (int i = 0; i < 4; i++)
          if (out_tdata[i*WORD_BITS +: WORD_BITS] !== want.r[i]) begin
            $error("r[%0d]: expected %0d, actual %0d", i, want.r[i],
                   $signed(out_tdata[i*WORD_BITS +: WORD_BITS]));
            error_count++;
          end
        if (out_tuser[0] !== want.sat) begin
          $error("saturated: expected %b, actual %b", want.sat, out_tuser[0]);
          error_count++;
        end
        if (out_tuser[1] !== want.zn) begin
          $error("zero_norm: expected %b, actual %b", want.zn, out_tuser[1]);
          error_count++;
        end
      end
    end
    // Watchdog on cycles without any transfer.
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

/* sim.f */
hw/rtl/qau_pkg.sv
hw/rtl/qau_norm.sv
hw/rtl/quaternion_arith_unit_core.sv
tb/sv/quaternion_arith_unit_core_tb.sv
